/* rtl/iqf_pkg.sv */
`default_nettype none
package iqf_pkg;

  localparam int RAW_W      = 8;
  localparam int SAMPLE_W   = 9;
  localparam int IDX_IN_W   = 7;
  localparam int COEF_IN_W  = 16;
  localparam int TAPCNT_W   = 8;
  localparam int GAIN_W     = 16;
  localparam int GAIN_SHIFT = 16;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [RAW_W-1:0] SAMPLE_BIAS = 8'd127;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 2'd1;

  localparam logic [TAPCNT_W-1:0] TAP_COUNT_RESET   = 8'd128;
  localparam logic [GAIN_W-1:0]   OUTPUT_GAIN_RESET = 16'd655;

  // Tags that travel with each tap product through the MAC pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage
`default_nettype wire

/* rtl/iqf_if.sv */
`default_nettype none
interface iqf_item_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   operation;
  logic        [iqf_pkg::RAW_W-1:0]       sample_i;
  logic        [iqf_pkg::RAW_W-1:0]       sample_q;
  logic        [iqf_pkg::IDX_IN_W-1:0]    coef_index;
  logic signed [iqf_pkg::COEF_IN_W-1:0]   coef_value;

  modport source(output valid, operation, sample_i, sample_q, coef_index, coef_value,
                 input ready);
  modport sink(input valid, operation, sample_i, sample_q, coef_index, coef_value,
               output ready);
endinterface

interface iqf_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [iqf_pkg::OUT_W-1:0]   filtered_i;
  logic signed [iqf_pkg::OUT_W-1:0]   filtered_q;

  modport source(output valid, filtered_i, filtered_q, input ready);
  modport sink(input valid, filtered_i, filtered_q, output ready);
endinterface

interface iqf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [iqf_pkg::CFG_IDX_W-1:0]     index;
  logic [iqf_pkg::CFG_DATA_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/iqf_sample_store.sv */
`default_nettype none
module iqf_sample_store #(
  parameter int MAX_TAPS = 128
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    wr_en,
  input  wire logic        [$clog2(MAX_TAPS)-1:0]      wr_addr,
  input  wire logic signed [iqf_pkg::SAMPLE_W-1:0]     wr_i,
  input  wire logic signed [iqf_pkg::SAMPLE_W-1:0]     wr_q,
  input  wire logic                                    rd_en,
  input  wire logic        [$clog2(MAX_TAPS)-1:0]      rd_addr,
  output logic signed      [iqf_pkg::SAMPLE_W-1:0]     rd_i,
  output logic signed      [iqf_pkg::SAMPLE_W-1:0]     rd_q,
  output logic                                         busy
);

  localparam int AW = $clog2(MAX_TAPS);
  localparam int SW = iqf_pkg::SAMPLE_W;

  logic [2*SW-1:0] mem [MAX_TAPS];
  logic [AW-1:0]   clr_addr;
  logic [2*SW-1:0] rd_word;

  // sweep zeros through both delay lines after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AW'(MAX_TAPS - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= {wr_i, wr_q};
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_i = $signed(rd_word[2*SW-1:SW]);
  assign rd_q = $signed(rd_word[SW-1:0]);

endmodule
`default_nettype wire

/* rtl/iqf_tap_store.sv */
`default_nettype none
module iqf_tap_store #(
  parameter int MAX_TAPS  = 128,
  parameter int COEF_BITS = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic        [iqf_pkg::IDX_IN_W-1:0]     wr_index,
  input  wire logic signed [iqf_pkg::COEF_IN_W-1:0]    wr_value,
  input  wire logic                                    rd_en,
  input  wire logic        [$clog2(MAX_TAPS)-1:0]      rd_addr,
  output logic signed      [COEF_BITS-1:0]             rd_coef
);

  localparam int AW = $clog2(MAX_TAPS);
  localparam int EW = (COEF_BITS > iqf_pkg::COEF_IN_W) ? COEF_BITS : iqf_pkg::COEF_IN_W;
  localparam logic signed [EW-1:0] COEF_HI = EW'((64'sd1 <<< (COEF_BITS - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] COEF_LO = -COEF_HI - EW'(1);

  logic signed [COEF_BITS-1:0] mem [MAX_TAPS];
  logic signed [EW-1:0]        value_ext;
  logic signed [COEF_BITS-1:0] value_sat;
  logic                        index_ok;

  always_comb begin
    value_ext = EW'(wr_value);
    if (value_ext > COEF_HI) begin
      value_sat = COEF_BITS'(COEF_HI);
    end else if (value_ext < COEF_LO) begin
      value_sat = COEF_BITS'(COEF_LO);
    end else begin
      value_sat = COEF_BITS'(value_ext);
    end
    // drop loads aimed past the end of the table
    index_ok = (int'(wr_index) < MAX_TAPS);
  end

  always_ff @(posedge clk) begin
    if (wr_en && index_ok) begin
      mem[AW'(wr_index)] <= value_sat;
    end
    if (rd_en) begin
      rd_coef <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/iqf_mac.sv */
`default_nettype none
module iqf_mac #(
  parameter int MAX_TAPS  = 128,
  parameter int COEF_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire iqf_pkg::mac_ctrl_t                   ctrl,
  input  wire logic signed [iqf_pkg::SAMPLE_W-1:0]  x_i,
  input  wire logic signed [iqf_pkg::SAMPLE_W-1:0]  x_q,
  input  wire logic signed [COEF_BITS-1:0]          coef,
  input  wire logic        [iqf_pkg::GAIN_W-1:0]    gain,
  output logic                                      done,
  output logic signed      [iqf_pkg::OUT_W-1:0]     filtered_i,
  output logic signed      [iqf_pkg::OUT_W-1:0]     filtered_q
);

  localparam int AW     = $clog2(MAX_TAPS);
  localparam int PW     = iqf_pkg::SAMPLE_W + COEF_BITS;
  localparam int ACC_W  = PW + AW;
  localparam int GW     = ACC_W + iqf_pkg::GAIN_W + 1;
  localparam int SHW    = GW - iqf_pkg::GAIN_SHIFT;
  localparam int EXT_W  = (SHW > iqf_pkg::OUT_W) ? SHW : iqf_pkg::OUT_W + 1;
  localparam int OW     = iqf_pkg::OUT_W;

  iqf_pkg::mac_ctrl_t ctrl_p;
  logic signed [PW-1:0]    prod_i, prod_q;
  logic signed [ACC_W-1:0] acc_i, acc_q;
  logic                    acc_done;
  logic signed [GW-1:0]    scaled_i, scaled_q;
  logic                    scaled_done;
  logic signed [EXT_W-1:0] ext_i, ext_q;
  logic signed [OW-1:0]    sat_i, sat_q;

  function automatic logic signed [OW-1:0] saturate(input logic signed [EXT_W-1:0] v);
    logic [EXT_W-OW:0] top;
    top = v[EXT_W-1:OW-1];
    if (top == '0 || top == '1) begin
      saturate = v[OW-1:0];
    end else if (v[EXT_W-1]) begin
      saturate = {1'b1, {(OW-1){1'b0}}};
    end else begin
      saturate = {1'b0, {(OW-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_p      <= '0;
      acc_done    <= 1'b0;
      scaled_done <= 1'b0;
      done        <= 1'b0;
    end else begin
      ctrl_p      <= ctrl;
      acc_done    <= ctrl_p.valid && ctrl_p.last;
      scaled_done <= acc_done;
      done        <= scaled_done;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      prod_i <= x_i * coef;
      prod_q <= x_q * coef;
    end
    if (ctrl_p.valid) begin
      if (ctrl_p.first) begin
        acc_i <= ACC_W'(prod_i);
        acc_q <= ACC_W'(prod_q);
      end else begin
        acc_i <= acc_i + ACC_W'(prod_i);
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
    if (acc_done) begin
      scaled_i <= acc_i * $signed({1'b0, gain});
      scaled_q <= acc_q * $signed({1'b0, gain});
    end
    // hold the result until the next word is finished
    if (scaled_done) begin
      filtered_i <= sat_i;
      filtered_q <= sat_q;
    end
  end

  // floor shift by dropping the fraction bits, then clip to 32 bits
  always_comb begin
    ext_i = EXT_W'($signed(scaled_i[GW-1:iqf_pkg::GAIN_SHIFT]));
    ext_q = EXT_W'($signed(scaled_q[GW-1:iqf_pkg::GAIN_SHIFT]));
    sat_i = saturate(ext_i);
    sat_q = saturate(ext_q);
  end

endmodule
`default_nettype wire

/* rtl/iq_fir_filter_unit.sv */
// Sample word: walked over N taps, N being tap_count held to 1..MAX_TAPS, one tap per cycle
// read from the delay-line and coefficient memories into a shared I/Q multiply-accumulate;
// the result passes the MAC product, accumulator, gain and result registers to the output
// register; the next word is taken once it is loaded, later while an earlier result still waits.
// Coefficient word: written in the cycle it is accepted; the next word is taken at once.
// Reset (rst, synchronous): defaults, then a pass over every slot zeroes the delay lines.
`default_nettype none
module iq_fir_filter_unit #(
  parameter int MAX_TAPS  = 128,
  parameter int COEF_BITS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  iqf_item_if.sink    items,
  iqf_result_if.source results,
  iqf_cfg_if.sink     cfg
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int NW    = $clog2(MAX_TAPS + 1);
  localparam int CMP_W = (NW > iqf_pkg::TAPCNT_W) ? NW : iqf_pkg::TAPCNT_W;
  localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_TAPS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                      state;
  logic [iqf_pkg::TAPCNT_W-1:0]    tap_count;
  logic [iqf_pkg::GAIN_W-1:0]      output_gain;
  logic [AW-1:0]                   newest_position;
  logic [AW-1:0]                   pos_next;
  logic [NW-1:0]                   n_taps;
  logic [NW-1:0]                   n_reg;
  logic [CMP_W-1:0]                tc_ext;
  logic [AW-1:0]                   k;
  logic [AW-1:0]                   j;
  logic                            walk_last;

  logic                            accept;
  logic                            take_sample;
  logic                            take_coef;
  logic                            clr_busy;
  logic                            slot_free;
  logic                            out_load;
  logic                            out_valid;
  logic signed [iqf_pkg::OUT_W-1:0] out_i, out_q;

  iqf_pkg::mac_ctrl_t              issue_ctrl;
  iqf_pkg::mac_ctrl_t              rd_ctrl;
  logic signed [iqf_pkg::SAMPLE_W-1:0] wr_i, wr_q, rd_i, rd_q;
  logic signed [COEF_BITS-1:0]     rd_coef;
  logic                            mac_done;
  logic signed [iqf_pkg::OUT_W-1:0] mac_i, mac_q;

  assign items.ready = (state == ST_IDLE) && !clr_busy;
  assign accept      = items.valid && items.ready;
  assign take_sample = accept && (items.operation == iqf_pkg::OP_SAMPLE);
  assign take_coef   = accept && (items.operation == iqf_pkg::OP_COEF);
  assign cfg.ready   = 1'b1;

  assign results.valid      = out_valid;
  assign results.filtered_i = out_i;
  assign results.filtered_q = out_q;
  assign slot_free          = !out_valid || results.ready;
  assign out_load           = ((state == ST_WAIT && mac_done) || state == ST_EMIT) && slot_free;

  always_comb begin
    tc_ext = CMP_W'(tap_count);
    if (tc_ext == '0) begin
      n_taps = NW'(1);
    end else if (tc_ext > MAX_EXT) begin
      n_taps = NW'(MAX_TAPS);
    end else begin
      n_taps = NW'(tc_ext);
    end
    // step back one slot; wrap to the top when at zero or beyond a shortened line
    if (newest_position == '0 || NW'(newest_position) >= n_taps) begin
      pos_next = AW'(n_taps - NW'(1));
    end else begin
      pos_next = newest_position - AW'(1);
    end
    wr_i = $signed(iqf_pkg::SAMPLE_W'(items.sample_i) - iqf_pkg::SAMPLE_W'(iqf_pkg::SAMPLE_BIAS));
    wr_q = $signed(iqf_pkg::SAMPLE_W'(items.sample_q) - iqf_pkg::SAMPLE_W'(iqf_pkg::SAMPLE_BIAS));
    walk_last        = (NW'(j) == n_reg - NW'(1));
    issue_ctrl.valid = (state == ST_WALK);
    issue_ctrl.first = (j == '0);
    issue_ctrl.last  = walk_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count   <= iqf_pkg::TAP_COUNT_RESET;
      output_gain <= iqf_pkg::OUTPUT_GAIN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        iqf_pkg::REG_TAP_COUNT:   tap_count   <= cfg.data[iqf_pkg::TAPCNT_W-1:0];
        iqf_pkg::REG_OUTPUT_GAIN: output_gain <= cfg.data[iqf_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      newest_position <= '0;
      out_valid       <= 1'b0;
      rd_ctrl         <= '0;
    end else begin
      rd_ctrl <= issue_ctrl;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take_sample) begin
            newest_position <= pos_next;
            state           <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_last) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            if (slot_free) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take_sample) begin
      k     <= pos_next;
      j     <= '0;
      n_reg <= n_taps;
    end else if (state == ST_WALK) begin
      j <= j + AW'(1);
      if (NW'(k) == n_reg - NW'(1)) begin
        k <= '0;
      end else begin
        k <= k + AW'(1);
      end
    end
    if (out_load) begin
      out_i <= mac_i;
      out_q <= mac_q;
    end
  end

  iqf_sample_store #(
    .MAX_TAPS(MAX_TAPS)
  ) u_sample_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take_sample),
    .wr_addr (pos_next),
    .wr_i    (wr_i),
    .wr_q    (wr_q),
    .rd_en   (issue_ctrl.valid),
    .rd_addr (k),
    .rd_i    (rd_i),
    .rd_q    (rd_q),
    .busy    (clr_busy)
  );

  iqf_tap_store #(
    .MAX_TAPS  (MAX_TAPS),
    .COEF_BITS (COEF_BITS)
  ) u_tap_store (
    .clk      (clk),
    .wr_en    (take_coef),
    .wr_index (items.coef_index),
    .wr_value (items.coef_value),
    .rd_en    (issue_ctrl.valid),
    .rd_addr  (j),
    .rd_coef  (rd_coef)
  );

  iqf_mac #(
    .MAX_TAPS  (MAX_TAPS),
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (rd_ctrl),
    .x_i        (rd_i),
    .x_q        (rd_q),
    .coef       (rd_coef),
    .gain       (output_gain),
    .done       (mac_done),
    .filtered_i (mac_i),
    .filtered_q (mac_q)
  );

endmodule
`default_nettype wire
